FILE: rtl/mfep_pkg.sv
// Shared types and constants of the MIDI file event parser.
// No dependencies; every other file of the block imports this package.
package mfep_pkg;

  localparam logic [31:0] MAGIC_HEAD  = 32'h6468_544D;
  localparam logic [31:0] MAGIC_TRACK = 32'h6B72_544D;

  localparam logic [7:0] DATA_MASK    = 8'h7F;
  localparam logic [7:0] STATUS_BIT   = 8'h80;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] META_STATUS  = 8'hFF;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_NOTE   = 3'd1,
    KIND_TEMPO  = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_ERROR  = 3'd4
  } event_kind_e;

  typedef struct packed {
    event_kind_e kind;
    logic [31:0] tick;
    logic [7:0]  key;
    logic [31:0] tempo;
    logic [15:0] track_index;
    logic [15:0] track_count;
    logic [15:0] division;
  } result_t;

endpackage

FILE: rtl/mfep_core.sv
// Parser state and the single-pass next-state logic for one file byte.
// Depends on mfep_pkg for the magic words, status codes and result type.
module mfep_core
  import mfep_pkg::*;
#(
  parameter int TICK_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        start_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  typedef enum logic [4:0] {
    PH_MTHD, PH_HSKIP, PH_NTRK, PH_DIV, PH_MTRK, PH_TLEN, PH_DELTA, PH_EVENT,
    PH_KEY9, PH_VEL9, PH_RVEL, PH_DATA, PH_SYSEX, PH_MTYPE, PH_MLEN, PH_MSKIP,
    PH_TEMPO, PH_DONEP, PH_IDLE
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [3:0]              fbc_q, fbc_d;
  logic [15:0]             ttot_q, ttot_d;
  logic [15:0]             tfin_q, tfin_d;
  logic [31:0]             tbl_q, tbl_d;
  logic [TICK_WIDTH-1:0]   tick_q, tick_d;
  logic [31:0]             dacc_q, dacc_d;
  logic [7:0]              mtype_q, mtype_d;
  logic [7:0]              mlen_q, mlen_d;
  logic [31:0]             tacc_q, tacc_d;
  logic [7:0]              pkey_q, pkey_d;
  logic [15:0]             hdiv_q, hdiv_d;

  logic                    emit;
  logic                    body;
  logic                    failed;
  logic                    fin_chk;

  always_comb begin
    phase_d  = phase_q;
    fbc_d    = fbc_q;
    ttot_d   = ttot_q;
    tfin_d   = tfin_q;
    tbl_d    = tbl_q;
    tick_d   = tick_q;
    dacc_d   = dacc_q;
    mtype_d  = mtype_q;
    mlen_d   = mlen_q;
    tacc_d   = tacc_q;
    pkey_d   = pkey_q;
    hdiv_d   = hdiv_q;
    if (start_i) begin
      phase_d = PH_MTHD;
      fbc_d   = '0;
      ttot_d  = '0;
      tfin_d  = '0;
      tbl_d   = '0;
      tick_d  = '0;
      dacc_d  = '0;
      mtype_d = '0;
      mlen_d  = '0;
      tacc_d  = '0;
      pkey_d  = '0;
      hdiv_d  = '0;
    end

    emit    = 1'b0;
    res_o   = '0;
    body    = 1'b0;
    failed  = 1'b0;
    fin_chk = 1'b0;

    case (phase_d)
      PH_MTHD, PH_MTRK: begin
        if (byte_i != (phase_d == PH_MTHD ? MAGIC_HEAD[{fbc_d[1:0], 3'b000} +: 8]
                                          : MAGIC_TRACK[{fbc_d[1:0], 3'b000} +: 8])) begin
          emit       = 1'b1;
          res_o.kind = KIND_ERROR;
          res_o.track_index = tfin_d;
          res_o.track_count = ttot_d;
          res_o.division    = hdiv_d;
          phase_d    = PH_IDLE;
        end else begin
          fbc_d = fbc_d + 4'd1;
          if (fbc_d == 4'd4) begin
            fbc_d = '0;
            if (phase_d == PH_MTHD) begin
              phase_d = PH_HSKIP;
            end else begin
              tbl_d   = '0;
              phase_d = PH_TLEN;
            end
          end
        end
      end
      PH_HSKIP: begin
        fbc_d = fbc_d + 4'd1;
        if (fbc_d == 4'd6) begin
          fbc_d   = '0;
          phase_d = PH_NTRK;
        end
      end
      PH_NTRK: begin
        ttot_d = {ttot_d[7:0], byte_i};
        fbc_d  = fbc_d + 4'd1;
        if (fbc_d == 4'd2) begin
          fbc_d   = '0;
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        hdiv_d = {hdiv_d[7:0], byte_i};
        fbc_d  = fbc_d + 4'd1;
        if (fbc_d == 4'd2) begin
          fbc_d   = '0;
          phase_d = (ttot_d == '0) ? PH_DONEP : PH_MTRK;
          emit    = 1'b1;
          res_o.kind        = KIND_HEADER;
          res_o.track_index = tfin_d;
          res_o.track_count = ttot_d;
          res_o.division    = hdiv_d;
        end
      end
      PH_TLEN: begin
        tbl_d = {tbl_d[23:0], byte_i};
        fbc_d = fbc_d + 4'd1;
        if (fbc_d == 4'd4) begin
          fbc_d   = '0;
          tick_d  = '0;
          dacc_d  = '0;
          phase_d = PH_DELTA;
          if (tbl_d == '0) begin
            fin_chk = 1'b1;
          end
        end
      end
      PH_DONEP: begin
        phase_d    = PH_IDLE;
        emit       = 1'b1;
        res_o.kind = KIND_DONE;
        res_o.track_index = tfin_d;
        res_o.track_count = ttot_d;
        res_o.division    = hdiv_d;
      end
      PH_IDLE: begin
      end
      PH_DELTA, PH_EVENT, PH_KEY9, PH_VEL9, PH_RVEL, PH_DATA, PH_SYSEX,
      PH_MTYPE, PH_MLEN, PH_MSKIP, PH_TEMPO: begin
        body = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // Every byte inside a track body uses up one byte of the track length.
    if (body) begin
      if (tbl_d != '0) begin
        tbl_d = tbl_d - 32'd1;
      end
      case (phase_d)
        PH_DELTA: begin
          dacc_d = {dacc_d[24:0], byte_i[6:0] & DATA_MASK[6:0]};
          if ((byte_i & STATUS_BIT) == '0) begin
            tick_d  = tick_d + TICK_WIDTH'(dacc_d);
            dacc_d  = '0;
            phase_d = PH_EVENT;
          end
        end
        PH_EVENT: begin
          if ((byte_i & STATUS_BIT) != '0) begin
            case (byte_i[7:4])
              4'h9: phase_d = PH_KEY9;
              4'h8, 4'hA, 4'hB, 4'hE: begin
                fbc_d   = 4'd2;
                phase_d = PH_DATA;
              end
              4'hC, 4'hD: begin
                fbc_d   = 4'd1;
                phase_d = PH_DATA;
              end
              default: begin
                if (byte_i == SYSEX_START || byte_i == SYSEX_END) begin
                  phase_d = PH_SYSEX;
                end else if (byte_i == META_STATUS) begin
                  phase_d = PH_MTYPE;
                end else begin
                  failed     = 1'b1;
                  emit       = 1'b1;
                  res_o.kind = KIND_ERROR;
                  res_o.track_index = tfin_d;
                  res_o.track_count = ttot_d;
                  res_o.division    = hdiv_d;
                  phase_d    = PH_IDLE;
                end
              end
            endcase
          end else begin
            pkey_d  = byte_i;
            phase_d = PH_RVEL;
          end
        end
        PH_KEY9: begin
          emit       = 1'b1;
          res_o.kind = KIND_NOTE;
          res_o.tick = 32'(tick_d);
          res_o.key  = byte_i;
          res_o.track_index = tfin_d;
          res_o.track_count = ttot_d;
          res_o.division    = hdiv_d;
          phase_d    = PH_VEL9;
        end
        PH_VEL9: phase_d = PH_DELTA;
        PH_RVEL: begin
          // A running-status note with zero velocity is a note-off.
          if (byte_i != '0) begin
            emit       = 1'b1;
            res_o.kind = KIND_NOTE;
            res_o.tick = 32'(tick_d);
            res_o.key  = pkey_d;
            res_o.track_index = tfin_d;
            res_o.track_count = ttot_d;
            res_o.division    = hdiv_d;
          end
          phase_d = PH_DELTA;
        end
        PH_DATA: begin
          fbc_d = fbc_d - 4'd1;
          if (fbc_d == '0) begin
            phase_d = PH_DELTA;
          end
        end
        PH_SYSEX: begin
          if (byte_i == SYSEX_END) begin
            phase_d = PH_DELTA;
          end
        end
        PH_MTYPE: begin
          mtype_d = byte_i;
          phase_d = PH_MLEN;
        end
        PH_MLEN: begin
          mlen_d  = byte_i;
          phase_d = PH_DELTA;
          if (mtype_d == META_TEMPO) begin
            tacc_d = '0;
            if (byte_i == '0) begin
              emit       = 1'b1;
              res_o.kind = KIND_TEMPO;
              res_o.tick = 32'(tick_d);
              res_o.track_index = tfin_d;
              res_o.track_count = ttot_d;
              res_o.division    = hdiv_d;
            end else begin
              phase_d = PH_TEMPO;
            end
          end else if (mtype_d == META_EOT) begin
            tbl_d = '0;
          end else if (byte_i != '0 && {24'd0, byte_i} <= tbl_d) begin
            phase_d = PH_MSKIP;
          end
        end
        PH_MSKIP: begin
          mlen_d = mlen_d - 8'd1;
          if (mlen_d == '0) begin
            phase_d = PH_DELTA;
          end
        end
        PH_TEMPO: begin
          tacc_d = {tacc_d[23:0], byte_i};
          mlen_d = mlen_d - 8'd1;
          if (mlen_d == '0) begin
            emit        = 1'b1;
            res_o.kind  = KIND_TEMPO;
            res_o.tick  = 32'(tick_d);
            res_o.tempo = tacc_d;
            res_o.track_index = tfin_d;
            res_o.track_count = ttot_d;
            res_o.division    = hdiv_d;
            phase_d     = PH_DELTA;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
      if (!failed && phase_d != PH_TEMPO && tbl_d == '0) begin
        fin_chk = 1'b1;
      end
    end

    // The track is used up: move to the next one or close the file.
    if (fin_chk) begin
      tfin_d = tfin_d + 16'd1;
      if (tfin_d == ttot_d) begin
        if (emit) begin
          phase_d = PH_DONEP;
        end else begin
          phase_d    = PH_IDLE;
          emit       = 1'b1;
          res_o      = '0;
          res_o.kind = KIND_DONE;
          res_o.track_index = tfin_d;
          res_o.track_count = ttot_d;
          res_o.division    = hdiv_d;
        end
      end else begin
        phase_d = PH_MTRK;
        fbc_d   = '0;
      end
    end

    res_valid_o = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MTHD;
      fbc_q   <= '0;
      ttot_q  <= '0;
      tfin_q  <= '0;
      tbl_q   <= '0;
      tick_q  <= '0;
      dacc_q  <= '0;
      mtype_q <= '0;
      mlen_q  <= '0;
      tacc_q  <= '0;
      pkey_q  <= '0;
      hdiv_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      ttot_q  <= ttot_d;
      tfin_q  <= tfin_d;
      tbl_q   <= tbl_d;
      tick_q  <= tick_d;
      dacc_q  <= dacc_d;
      mtype_q <= mtype_d;
      mlen_q  <= mlen_d;
      tacc_q  <= tacc_d;
      pkey_q  <= pkey_d;
      hdiv_q  <= hdiv_d;
    end
  end

  a_tracks_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tfin_q <= ttot_q)
    else $error("finished track count passed the header track count");

  a_tempo_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TEMPO |-> mlen_q != '0)
    else $error("tempo payload phase with no bytes left");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> (fbc_q == 4'd1 || fbc_q == 4'd2))
    else $error("channel data skip count out of range");

  a_magic_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MTHD || phase_q == PH_MTRK || phase_q == PH_TLEN) |-> fbc_q < 4'd4)
    else $error("four-byte field count out of range");

endmodule

FILE: rtl/mfep_out_buf.sv
// Result register between the parser and the output channel.
// Depends on mfep_pkg for the result type.
module mfep_out_buf
  import mfep_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  output logic    ready_o,
  input  logic    stall_i,
  output logic    valid_o,
  output result_t data_o
);

  logic    valid_q;
  result_t data_q;

  // The register can take a new result when empty or when it empties now.
  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

FILE: rtl/midi_file_event_parser.sv
// An accepted byte is held in the input register, and its result is then loaded into the result register.
// Throughput: one byte per cycle; input stalls only while a result waits and the output stalls.
// Bytes that cause no result pass through without waiting on the output side.
// Reset: asynchronous, active low; the parser waits for a file header with all counts at zero.
// Depends on mfep_pkg, mfep_core and mfep_out_buf.
module midi_file_event_parser
  import mfep_pkg::*;
#(
  parameter int TICK_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [31:0] tick_o,
  output logic [7:0]  note_key_o,
  output logic [31:0] tempo_value_o,
  output logic [15:0] track_index_o,
  output logic [15:0] track_count_o,
  output logic [15:0] division_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       buf_ready;
  result_t    out_data;

  assign advance    = in_valid_q && (!res_valid || buf_ready);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= data_byte_i;
      start_q <= file_start_i;
    end
  end

  mfep_core #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (byte_q),
    .start_i    (start_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  mfep_out_buf u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && res_valid),
    .data_i (res),
    .ready_o(buf_ready),
    .stall_i(out_stall_i),
    .valid_o(out_valid_o),
    .data_o (out_data)
  );

  assign event_kind_o  = out_data.kind;
  assign tick_o        = out_data.tick;
  assign note_key_o    = out_data.key;
  assign tempo_value_o = out_data.tempo;
  assign track_index_o = out_data.track_index;
  assign track_count_o = out_data.track_count;
  assign division_o    = out_data.division;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && res_valid))
    else $error("input stalled without a blocked result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("held result dropped while stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid) |=> out_valid_o)
    else $error("parsed result did not reach the output register");

endmodule

FILE: test/midi_event_checker.sv
// Status nibble codes shared by the stimulus and the checker, and the checker itself.
// The checker rebuilds the parser's results from the accepted bytes and compares them.
// Depends on mfep_pkg.
package midi_status_pkg;

  typedef enum logic [3:0] {
    ST_NOTE_OFF   = 4'h8,
    ST_NOTE_ON    = 4'h9,
    ST_KEY_PRESS  = 4'hA,
    ST_CONTROL    = 4'hB,
    ST_PROGRAM    = 4'hC,
    ST_CHAN_PRESS = 4'hD,
    ST_PITCH_BEND = 4'hE,
    ST_SYSTEM     = 4'hF
  } status_nibble_e;

endpackage

module midi_event_checker
  import mfep_pkg::*;
  import midi_status_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  event_kind_i,
  input  logic [31:0] tick_i,
  input  logic [7:0]  note_key_i,
  input  logic [31:0] tempo_value_i,
  input  logic [15:0] track_index_i,
  input  logic [15:0] track_count_i,
  input  logic [15:0] division_i,
  output int          pending_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [4:0] {
    WAIT_MTHD, SKIP_HDR, READ_NTRK, READ_DIV, WAIT_MTRK, READ_LEN,
    READ_DELTA, READ_EVENT, NOTE_KEY, NOTE_VEL, RUN_VEL, SKIP_DATA,
    SKIP_SYSEX, READ_MTYPE, READ_MLEN, SKIP_META, READ_TEMPO, DONE_NEXT,
    IGNORE_REST
  } parse_phase_e;

  parse_phase_e phase;
  logic [3:0]   field_cnt;
  logic [15:0]  trk_total;
  logic [15:0]  trk_done;
  logic [15:0]  hdr_div;
  logic [31:0]  bytes_left;
  logic [31:0]  trk_tick;
  logic [31:0]  delta_acc;
  logic [31:0]  tempo_acc;
  logic [7:0]   mtype;
  logic [7:0]   mlen;
  logic [7:0]   held_key;

  result_t expected_events[$];
  int      mismatch_count = 0;

  assign errors_o = mismatch_count;

  task automatic clear_parser();
    phase      = WAIT_MTHD;
    field_cnt  = '0;
    trk_total  = '0;
    trk_done   = '0;
    hdr_div    = '0;
    bytes_left = '0;
    trk_tick   = '0;
    delta_acc  = '0;
    tempo_acc  = '0;
    mtype      = '0;
    mlen       = '0;
    held_key   = '0;
  endtask

  function automatic result_t make_event(event_kind_e kind, logic [31:0] tk,
                                         logic [7:0] key, logic [31:0] tempo);
    result_t r;
    r.kind        = kind;
    r.tick        = tk;
    r.key         = key;
    r.tempo       = tempo;
    r.track_index = trk_done;
    r.track_count = trk_total;
    r.division    = hdr_div;
    return r;
  endfunction

  task automatic raise_error(output logic got, output result_t r);
    phase = IGNORE_REST;
    got   = 1'b1;
    r     = make_event(KIND_ERROR, '0, '0, '0);
  endtask

  // A result already pending on this byte pushes the done report to the next byte.
  task automatic end_track(inout logic got, inout result_t r);
    trk_done = trk_done + 16'd1;
    if (trk_done == trk_total) begin
      if (got) begin
        phase = DONE_NEXT;
      end else begin
        phase = IGNORE_REST;
        got   = 1'b1;
        r     = make_event(KIND_DONE, '0, '0, '0);
      end
    end else begin
      phase     = WAIT_MTRK;
      field_cnt = '0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic start,
                            output logic got, output result_t r);
    logic in_track;
    got      = 1'b0;
    r        = '0;
    in_track = 1'b0;
    if (start) clear_parser();
    case (phase)
      WAIT_MTHD: begin
        if (MAGIC_HEAD[8*field_cnt[1:0] +: 8] != b) begin
          raise_error(got, r);
        end else if (field_cnt == 4'd3) begin
          field_cnt = '0;
          phase     = SKIP_HDR;
        end else begin
          field_cnt++;
        end
      end
      SKIP_HDR: begin
        if (field_cnt == 4'd5) begin
          field_cnt = '0;
          phase     = READ_NTRK;
        end else begin
          field_cnt++;
        end
      end
      READ_NTRK: begin
        trk_total = {trk_total[7:0], b};
        if (field_cnt == 4'd1) begin
          field_cnt = '0;
          phase     = READ_DIV;
        end else begin
          field_cnt++;
        end
      end
      READ_DIV: begin
        hdr_div = {hdr_div[7:0], b};
        if (field_cnt == 4'd1) begin
          field_cnt = '0;
          phase     = (trk_total == '0) ? DONE_NEXT : WAIT_MTRK;
          got       = 1'b1;
          r         = make_event(KIND_HEADER, '0, '0, '0);
        end else begin
          field_cnt++;
        end
      end
      WAIT_MTRK: begin
        if (MAGIC_TRACK[8*field_cnt[1:0] +: 8] != b) begin
          raise_error(got, r);
        end else if (field_cnt == 4'd3) begin
          field_cnt  = '0;
          bytes_left = '0;
          phase      = READ_LEN;
        end else begin
          field_cnt++;
        end
      end
      READ_LEN: begin
        bytes_left = {bytes_left[23:0], b};
        if (field_cnt == 4'd3) begin
          field_cnt = '0;
          trk_tick  = '0;
          delta_acc = '0;
          phase     = READ_DELTA;
          if (bytes_left == '0) end_track(got, r);
        end else begin
          field_cnt++;
        end
      end
      DONE_NEXT: begin
        phase = IGNORE_REST;
        got   = 1'b1;
        r     = make_event(KIND_DONE, '0, '0, '0);
      end
      IGNORE_REST: ;
      default: in_track = 1'b1;
    endcase

    if (in_track) begin
      // Every byte of the track body counts against the track length.
      if (bytes_left != '0) bytes_left--;
      case (phase)
        READ_DELTA: begin
          delta_acc = {delta_acc[24:0], b[6:0]};
          if (!b[7]) begin
            trk_tick  = trk_tick + delta_acc;
            delta_acc = '0;
            phase     = READ_EVENT;
          end
        end
        READ_EVENT: begin
          if (b[7]) begin
            case (b[7:4])
              ST_NOTE_ON: phase = NOTE_KEY;
              ST_NOTE_OFF, ST_KEY_PRESS, ST_CONTROL, ST_PITCH_BEND: begin
                field_cnt = 4'd2;
                phase     = SKIP_DATA;
              end
              ST_PROGRAM, ST_CHAN_PRESS: begin
                field_cnt = 4'd1;
                phase     = SKIP_DATA;
              end
              default: begin
                if (b == SYSEX_START || b == SYSEX_END) phase = SKIP_SYSEX;
                else if (b == META_STATUS) phase = READ_MTYPE;
                else raise_error(got, r);
              end
            endcase
          end else begin
            held_key = b;
            phase    = RUN_VEL;
          end
        end
        NOTE_KEY: begin
          got   = 1'b1;
          r     = make_event(KIND_NOTE, trk_tick, b, '0);
          phase = NOTE_VEL;
        end
        NOTE_VEL: phase = READ_DELTA;
        RUN_VEL: begin
          if (b != '0) begin
            got = 1'b1;
            r   = make_event(KIND_NOTE, trk_tick, held_key, '0);
          end
          phase = READ_DELTA;
        end
        SKIP_DATA: begin
          field_cnt = field_cnt - 4'd1;
          if (field_cnt == '0) phase = READ_DELTA;
        end
        SKIP_SYSEX: begin
          if (b == SYSEX_END) phase = READ_DELTA;
        end
        READ_MTYPE: begin
          mtype = b;
          phase = READ_MLEN;
        end
        READ_MLEN: begin
          mlen  = b;
          phase = READ_DELTA;
          if (mtype == META_TEMPO) begin
            tempo_acc = '0;
            if (b == '0) begin
              got = 1'b1;
              r   = make_event(KIND_TEMPO, trk_tick, '0, '0);
            end else begin
              phase = READ_TEMPO;
            end
          end else if (mtype == META_EOT) begin
            bytes_left = '0;
          end else if (b != '0 && b <= bytes_left) begin
            phase = SKIP_META;
          end
        end
        SKIP_META: begin
          mlen = mlen - 8'd1;
          if (mlen == '0) phase = READ_DELTA;
        end
        READ_TEMPO: begin
          tempo_acc = {tempo_acc[23:0], b};
          mlen      = mlen - 8'd1;
          if (mlen == '0) begin
            got   = 1'b1;
            r     = make_event(KIND_TEMPO, trk_tick, '0, tempo_acc);
            phase = READ_DELTA;
          end
        end
        default: ;
      endcase
      // The tempo payload is always read to its end, even past the track length.
      if (phase != READ_TEMPO && phase != IGNORE_REST && bytes_left == '0) end_track(got, r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      mismatch_count++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_words
    result_t want;
    logic    hit;
    if (!rst_ni) begin
      clear_parser();
      expected_events.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        parse_byte(data_byte_i, file_start_i, hit, want);
        if (hit) expected_events = {expected_events, want};
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, expected none actual kind %0d", $time, event_kind_i);
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", want.kind, event_kind_i);
          check_field("tick", want.tick, tick_i);
          check_field("note_key", want.key, note_key_i);
          check_field("tempo_value", want.tempo, tempo_value_i);
          check_field("track_index", want.track_index, track_index_i);
          check_field("track_count", want.track_count, track_count_i);
          check_field("division", want.division, division_i);
        end
      end
      pending_o <= expected_events.size();
    end
  end

endmodule

FILE: test/tb_midi_file_event_parser.sv
// Top of the MIDI file event parser testbench: builds byte streams of whole files,
// drives them with random gaps and output stalls, and gives the verdict.
// Depends on mfep_pkg, midi_status_pkg, midi_event_checker and midi_file_event_parser.
module tb_midi_file_event_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import mfep_pkg::*;
  import midi_status_pkg::*;

  typedef struct {
    logic [7:0] value;
    logic       first;
  } file_byte_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        file_start;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  event_kind;
  logic [31:0] tick;
  logic [7:0]  note_key;
  logic [31:0] tempo_value;
  logic [15:0] track_index;
  logic [15:0] track_count;
  logic [15:0] division;

  int         expected_left;
  int         mismatches;
  int         sent_count = 0;
  logic       quiet;
  file_byte_t byte_stream[$];
  logic [7:0] track_body[$];

  // No idling on either side for a stretch in the middle of the run.
  assign quiet = (sent_count >= 150 && sent_count < 300);

  always begin
    #1ns clk = 1'b1;
    #1ns clk = 1'b0;
  end

  midi_file_event_parser dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .file_start_i (file_start),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .event_kind_o (event_kind),
    .tick_o       (tick),
    .note_key_o   (note_key),
    .tempo_value_o(tempo_value),
    .track_index_o(track_index),
    .track_count_o(track_count),
    .division_o   (division)
  );

  midi_event_checker checker_u (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .data_byte_i  (data_byte),
    .file_start_i (file_start),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .event_kind_i (event_kind),
    .tick_i       (tick),
    .note_key_i   (note_key),
    .tempo_value_i(tempo_value),
    .track_index_i(track_index),
    .track_count_i(track_count),
    .division_i   (division),
    .pending_o    (expected_left),
    .errors_o     (mismatches)
  );

  function automatic void put(logic [7:0] v, logic first = 1'b0);
    file_byte_t fb;
    fb.value = v;
    fb.first = first;
    byte_stream = {byte_stream, fb};
  endfunction

  function automatic void body_put(logic [7:0] v);
    track_body = {track_body, v};
  endfunction

  // Magic bytes go out low byte first; bad_at picks one byte to corrupt, or none if negative.
  task automatic put_magic(logic [31:0] magic, logic first, int bad_at);
    logic [7:0] flip;
    for (int i = 0; i < 4; i++) begin
      flip = (i == bad_at) ? 8'($urandom_range(1, 255)) : 8'd0;
      put(magic[8*i +: 8] ^ flip, first && i == 0);
    end
  endtask

  // Variable-length delta: mostly one byte, now and then long enough to wrap.
  task automatic add_delta();
    int         nb;
    int         roll;
    logic [6:0] v;
    roll = $urandom_range(0, 99);
    nb = (roll < 60) ? 1 : (roll < 85) ? 2 : (roll < 95) ? int'($urandom_range(3, 4)) : 5;
    for (int i = 1; i < nb; i++) begin
      v = 7'($urandom_range(0, 127));
      body_put({1'b1, v});
    end
    v = 7'($urandom_range(0, 127));
    body_put({1'b0, v});
  endtask

  initial begin : make_files
    int             first_random;
    int             roll;
    int             n_tracks;
    int             n_events;
    int             len;
    logic [15:0]    ntrk;
    logic [3:0]     chan;
    logic [3:0]     low;
    logic [7:0]     mt;
    status_nibble_e nib;

    // A bad first magic byte, then a header with no tracks and the largest division.
    put(8'h00, 1'b1);
    put(8'hFF);
    put_magic(MAGIC_HEAD, 1'b1, -1);
    put(8'h00); put(8'hFF); put(8'h00); put(8'hFF); put(8'h55); put(8'hAA);
    put(8'h00); put(8'h00);
    put(8'hFF); put(8'hFF);
    put(8'h80);

    first_random = byte_stream.size();
    while (byte_stream.size() - first_random < 400) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) ntrk = '0;
      else if (roll < 20) ntrk = {8'hFF, 8'($urandom_range(0, 255))};
      else ntrk = 16'($urandom_range(1, 2));
      n_tracks = (ntrk > 16'd3) ? int'($urandom_range(1, 2)) : int'(ntrk);
      if (n_tracks > 0 && $urandom_range(0, 9) == 0) n_tracks--;

      put_magic(MAGIC_HEAD, 1'b1,
                ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1);
      repeat (6) put(8'($urandom_range(0, 255)));
      put(ntrk[15:8]);
      put(ntrk[7:0]);
      put(8'($urandom_range(0, 255)));
      put(8'($urandom_range(0, 255)));

      repeat (n_tracks) begin
        put_magic(MAGIC_TRACK, 1'b0,
                  ($urandom_range(0, 12) == 0) ? int'($urandom_range(0, 3)) : -1);
        track_body.delete();
        n_events = $urandom_range(1, 8);
        repeat (n_events) begin
          add_delta();
          roll = $urandom_range(0, 99);
          chan = 4'($urandom_range(0, 15));
          if (roll < 28) begin
            body_put({ST_NOTE_ON, chan});
            body_put(8'($urandom_range(0, 255)));
            body_put(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
          end else if (roll < 40) begin
            // Running status: a bare key, reported only with a nonzero velocity.
            body_put(8'($urandom_range(0, 127)));
            body_put(($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
          end else if (roll < 52) begin
            case ($urandom_range(0, 3))
              0: nib = ST_NOTE_OFF;
              1: nib = ST_KEY_PRESS;
              2: nib = ST_CONTROL;
              default: nib = ST_PITCH_BEND;
            endcase
            body_put({nib, chan});
            body_put(8'($urandom_range(0, 255)));
            body_put(8'($urandom_range(0, 255)));
          end else if (roll < 60) begin
            nib = $urandom_range(0, 1) ? ST_PROGRAM : ST_CHAN_PRESS;
            body_put({nib, chan});
            body_put(8'($urandom_range(0, 255)));
          end else if (roll < 66) begin
            body_put($urandom_range(0, 1) ? SYSEX_START : SYSEX_END);
            repeat ($urandom_range(0, 4)) body_put(8'($urandom_range(0, 127)));
            body_put(SYSEX_END);
          end else if (roll < 80) begin
            len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 6)) : 3;
            body_put(META_STATUS);
            body_put(META_TEMPO);
            body_put(8'(len));
            repeat (len) body_put(8'($urandom_range(0, 255)));
          end else if (roll < 93) begin
            mt = 8'($urandom_range(0, 255));
            if (mt == META_TEMPO || mt == META_EOT) mt = ~mt;
            len = int'($urandom_range(0, 5));
            body_put(META_STATUS);
            body_put(mt);
            // Sometimes the length claims more than the payload holds.
            body_put(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : 8'(len));
            repeat (len) body_put(8'($urandom_range(0, 255)));
          end else if (roll < 97) begin
            low = 4'($urandom_range(1, 13));
            if (low >= SYSEX_END[3:0]) low++;
            body_put({ST_SYSTEM, low});
          end else begin
            body_put(META_STATUS);
            body_put(META_EOT);
            body_put(8'd0);
          end
        end
        if ($urandom_range(0, 1)) begin
          add_delta();
          body_put(META_STATUS);
          body_put(META_EOT);
          body_put(8'd0);
        end

        len = track_body.size();
        roll = $urandom_range(0, 99);
        if (roll < 6) len = 0;
        else if (roll < 14) len = int'($urandom_range(1, len));
        else if (roll < 20) len = len + int'($urandom_range(1, 3));
        put(len[31:24]);
        put(len[23:16]);
        put(len[15:8]);
        put(len[7:0]);
        foreach (track_body[i]) put(track_body[i]);
      end
      // Trailing bytes let a deferred done report come out.
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 2) : 0) put(8'($urandom_range(0, 255)));
    end
  end

  initial begin : drive_bytes
    int idx;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    data_byte  <= '0;
    file_start <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idx = 0;
    while (idx < byte_stream.size()) begin
      if (!quiet && $urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        in_valid   <= 1'b1;
        data_byte  <= byte_stream[idx].value;
        file_start <= byte_stream[idx].first;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        idx++;
        sent_count = idx;
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Random output stalls, plus one long hold-off that backs the parser up into its input.
  initial begin : stall_results
    logic held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held_off && sent_count >= 60) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 7);
      end
    end
  end

  initial begin : watchdog
    #1ms;
    $display("simulation failed");
    $finish;
  end

endmodule
